### rtl/slbm_pkg.sv
// Shared types, constants and helpers for the serial loaded bank mapper.
// No dependencies; imported by slbm_core, serial_loaded_bank_mapper and the testbench.
`default_nettype none

package slbm_pkg;

    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned PRG_BANK_W  = 4;
    localparam int unsigned CHR_BANK_W  = 5;
    localparam int unsigned SHIFT_W     = 5;
    localparam int unsigned PRG_COUNT_W = 5;
    localparam int unsigned CHR_COUNT_W = 6;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 6;

    localparam logic [SHIFT_W-1:0]     SHIFT_MARKER    = 5'b10000;
    localparam logic [SHIFT_W-1:0]     CONTROL_RESET   = 5'h0C;
    localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 5'd2;
    localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_RESET = 6'd1;
    localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_MAX   = 5'd16;
    localparam logic [CHR_COUNT_W-1:0] CHR_COUNT_MAX   = 6'd32;

    localparam logic [CFG_IDX_W-1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_COUNT = 2'd1;

    typedef enum logic [1:0] {
        TGT_CONTROL = 2'd0,
        TGT_CHR0    = 2'd1,
        TGT_CHR1    = 2'd2,
        TGT_PRG     = 2'd3
    } t_target;

    localparam logic [1:0] PRG_MODE_FIX_LOWER = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_UPPER = 2'd3;

    typedef struct packed {
        logic                  handled;
        logic                  register_loaded;
        logic [PRG_BANK_W-1:0] prg_lower_bank;
        logic [PRG_BANK_W-1:0] prg_upper_bank;
        logic [CHR_BANK_W-1:0] chr_bank;
        logic [1:0]            mirror_mode;
        logic                  bank_out_of_range;
    } t_result;

    function automatic logic [PRG_COUNT_W-1:0] eff_prg_count(
        input logic [PRG_COUNT_W-1:0] count
    );
        logic [PRG_COUNT_W-1:0] eff;
        eff = count;
        if (count == '0) begin
            eff = PRG_COUNT_W'(1);
        end else if (count > PRG_COUNT_MAX) begin
            eff = PRG_COUNT_MAX;
        end
        return eff;
    endfunction

    function automatic logic [CHR_COUNT_W-1:0] eff_chr_count(
        input logic [CHR_COUNT_W-1:0] count
    );
        logic [CHR_COUNT_W-1:0] eff;
        eff = count;
        if (count == '0) begin
            eff = CHR_COUNT_W'(1);
        end else if (count > CHR_COUNT_MAX) begin
            eff = CHR_COUNT_MAX;
        end
        return eff;
    endfunction

    function automatic logic [PRG_BANK_W-1:0] last_prg_bank(
        input logic [PRG_COUNT_W-1:0] count
    );
        logic [PRG_COUNT_W-1:0] last;
        last = eff_prg_count(count) - PRG_COUNT_W'(1);
        return last[PRG_BANK_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/serial_loaded_bank_mapper.sv
// Top level of the serial loaded bank mapper: handshakes, count registers
// and the result register. Depends on slbm_pkg and slbm_core.
//
// Usage:
//   Input channel: i_valid / o_stall carry one CPU write (i_addr, i_data).
//   A transfer happens at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one result per write; a
//   transfer happens with o_valid high and i_stall low.
//   Config channel: i_cfg_valid / o_cfg_ready write i_cfg_index, i_cfg_data
//   (0 = program bank count, 1 = pattern bank count); other indexes drop.
//   o_cfg_ready is always high.
//   The result is registered and appears in the cycle after the input transfer.
//   Throughput: one write per cycle while not stalled; the mapper state is
//   updated in the same cycle the write is taken, feeding the single result
//   register. When the receiver stalls, the result register holds and o_stall
//   rises only while it is full; it drops as soon as the result is taken.
//   Reset (i_rst_n low, synchronous): counts return to 2 and 1, the shift
//   port to its marker, control to PRG mode 3, banks to their defaults,
//   and the output register empties.
`default_nettype none

module serial_loaded_bank_mapper
    import slbm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [DATA_W-1:0]     i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_handled,
    output logic                       o_register_loaded,
    output logic [PRG_BANK_W-1:0]      o_prg_lower_bank,
    output logic [PRG_BANK_W-1:0]      o_prg_upper_bank,
    output logic [CHR_BANK_W-1:0]      o_chr_bank,
    output logic [1:0]                 o_mirror_mode,
    output logic                       o_bank_out_of_range,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [PRG_COUNT_W-1:0] r_prg_count;
    logic [CHR_COUNT_W-1:0] r_chr_count;
    logic                   r_out_valid;
    t_result                r_out;
    t_result                result;
    logic                   accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count <= PRG_COUNT_RESET;
            r_chr_count <= CHR_COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PRG_COUNT: r_prg_count <= i_cfg_data[PRG_COUNT_W-1:0];
                CFG_CHR_COUNT: r_chr_count <= i_cfg_data[CHR_COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    slbm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_addr      (i_addr),
        .i_data      (i_data),
        .i_prg_count (r_prg_count),
        .i_chr_count (r_chr_count),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_handled           = r_out.handled;
    assign o_register_loaded   = r_out.register_loaded;
    assign o_prg_lower_bank    = r_out.prg_lower_bank;
    assign o_prg_upper_bank    = r_out.prg_upper_bank;
    assign o_chr_bank          = r_out.chr_bank;
    assign o_mirror_mode       = r_out.mirror_mode;
    assign o_bank_out_of_range = r_out.bank_out_of_range;

endmodule

`default_nettype wire

### rtl/slbm_core.sv
// Mapper state: serial shift port, control and bank registers, and the
// per-write result. Depends on slbm_pkg.
`default_nettype none

module slbm_core
    import slbm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire logic [ADDR_W-1:0]      i_addr,
    input  wire logic [DATA_W-1:0]      i_data,
    input  wire logic [PRG_COUNT_W-1:0] i_prg_count,
    input  wire logic [CHR_COUNT_W-1:0] i_chr_count,
    output t_result                     o_result
);

    logic [SHIFT_W-1:0]    r_shift,   n_shift;
    logic [SHIFT_W-1:0]    r_control, n_control;
    logic [PRG_BANK_W-1:0] r_lower,   n_lower;
    logic [PRG_BANK_W-1:0] r_upper,   n_upper;
    logic [CHR_BANK_W-1:0] r_pattern, n_pattern;

    logic [SHIFT_W-1:0]     shifted;
    logic [PRG_COUNT_W-1:0] prg_eff;
    logic [CHR_COUNT_W-1:0] chr_eff;
    logic                   handled;
    logic                   loaded;
    logic                   oor;
    t_target                target;

    assign shifted = {i_data[0], r_shift[SHIFT_W-1:1]};
    assign prg_eff = eff_prg_count(i_prg_count);
    assign chr_eff = eff_chr_count(i_chr_count);
    assign target  = t_target'(i_addr[14:13]);

    always_comb begin
        n_shift   = r_shift;
        n_control = r_control;
        n_lower   = r_lower;
        n_upper   = r_upper;
        n_pattern = r_pattern;
        handled   = 1'b0;
        loaded    = 1'b0;
        oor       = 1'b0;
        if (i_load && i_addr[ADDR_W-1]) begin
            handled = 1'b1;
            if (i_data[DATA_W-1]) begin
                n_shift = SHIFT_MARKER;
            end else if (!r_shift[0]) begin
                n_shift = shifted;
            end else begin
                loaded  = 1'b1;
                n_shift = SHIFT_MARKER;
                case (target)
                    TGT_CONTROL: begin
                        n_control = shifted;
                        if (shifted[3:2] == PRG_MODE_FIX_LOWER) begin
                            n_lower = '0;
                        end else if (shifted[3:2] == PRG_MODE_FIX_UPPER) begin
                            n_upper = last_prg_bank(i_prg_count);
                        end
                    end
                    TGT_CHR0: begin
                        if (!r_control[4]) begin
                            n_pattern = {1'b0, shifted[SHIFT_W-1:1]};
                            oor = {1'b0, n_pattern} >= chr_eff;
                        end
                    end
                    TGT_PRG: begin
                        oor = {1'b0, shifted[PRG_BANK_W-1:0]} >= prg_eff;
                        if (r_control[3:2] == PRG_MODE_FIX_UPPER) begin
                            n_lower = shifted[PRG_BANK_W-1:0];
                        end else if (r_control[3:2] == PRG_MODE_FIX_LOWER) begin
                            n_upper = shifted[PRG_BANK_W-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift   <= SHIFT_MARKER;
            r_control <= CONTROL_RESET;
            r_lower   <= '0;
            r_upper   <= last_prg_bank(PRG_COUNT_RESET);
            r_pattern <= '0;
        end else begin
            r_shift   <= n_shift;
            r_control <= n_control;
            r_lower   <= n_lower;
            r_upper   <= n_upper;
            r_pattern <= n_pattern;
        end
    end

    always_comb begin
        o_result.handled           = handled;
        o_result.register_loaded   = loaded;
        o_result.prg_lower_bank    = n_lower;
        o_result.prg_upper_bank    = n_upper;
        o_result.chr_bank          = n_pattern;
        o_result.mirror_mode       = n_control[1:0];
        o_result.bank_out_of_range = oor;
    end

`ifndef SYNTHESIS
    a_marker_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_shift != '0)
        else $error("shift register lost its marker bit");

    a_load_clears_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        loaded |=> r_shift == SHIFT_MARKER)
        else $error("shift register not cleared after a completed load");

    a_idle_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !handled |=> $stable(r_shift) && $stable(r_control) && $stable(r_lower)
            && $stable(r_upper) && $stable(r_pattern))
        else $error("mapper state changed without a handled write");

    a_oor_needs_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        oor |-> loaded && (target == TGT_PRG || target == TGT_CHR0))
        else $error("range flag raised outside a bank load");
`endif

endmodule

`default_nettype wire

### dv/tb_serial_loaded_bank_mapper.sv
// Self-checking testbench for serial_loaded_bank_mapper: directed and random CPU
// bus writes, each bank report checked against a cycle-free model of the mapper.
// Depends on slbm_pkg and the serial_loaded_bank_mapper RTL.
`default_nettype none

module tb_serial_loaded_bank_mapper;
    import slbm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int BLOCK_WRITES = 160;
    localparam int CHR_MODE_BIT = 4;

    localparam logic [ADDR_W-1:0]    WINDOW_BASE   = 16'h8000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [ADDR_W-1:0]     i_addr      = '0;
    logic [DATA_W-1:0]     i_data      = '0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_stall;
    logic                  o_valid;
    logic                  o_handled;
    logic                  o_register_loaded;
    logic [PRG_BANK_W-1:0] o_prg_lower_bank;
    logic [PRG_BANK_W-1:0] o_prg_upper_bank;
    logic [CHR_BANK_W-1:0] o_chr_bank;
    logic [1:0]            o_mirror_mode;
    logic                  o_bank_out_of_range;
    logic                  o_cfg_ready;

    logic [SHIFT_W-1:0]     shift_q;
    logic [SHIFT_W-1:0]     control_q;
    logic [PRG_BANK_W-1:0]  lower_bank_q;
    logic [PRG_BANK_W-1:0]  upper_bank_q;
    logic [CHR_BANK_W-1:0]  pattern_bank_q;
    logic [PRG_COUNT_W-1:0] prg_count_q;
    logic [CHR_COUNT_W-1:0] chr_count_q;

    t_result pending_reports[$];

    int send_idle_pct   = 19;
    int recv_idle_pct   = 66;
    int mismatches      = 0;
    int writes_taken    = 0;
    int loads_taken     = 0;
    int reports_checked = 0;
    int count_settings  = 0;
    int cycle_count     = 0;

    serial_loaded_bank_mapper uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_addr              (i_addr),
        .i_data              (i_data),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_handled           (o_handled),
        .o_register_loaded   (o_register_loaded),
        .o_prg_lower_bank    (o_prg_lower_bank),
        .o_prg_upper_bank    (o_prg_upper_bank),
        .o_chr_bank          (o_chr_bank),
        .o_mirror_mode       (o_mirror_mode),
        .o_bank_out_of_range (o_bank_out_of_range),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int prg_banks_present();
        if (prg_count_q == '0) return 1;
        if (prg_count_q > PRG_COUNT_MAX) return int'(PRG_COUNT_MAX);
        return int'(prg_count_q);
    endfunction

    function automatic int chr_banks_present();
        if (chr_count_q == '0) return 1;
        if (chr_count_q > CHR_COUNT_MAX) return int'(CHR_COUNT_MAX);
        return int'(chr_count_q);
    endfunction

    function automatic logic [PRG_BANK_W-1:0] top_prg_bank();
        int last;
        last = prg_banks_present() - 1;
        return last[PRG_BANK_W-1:0];
    endfunction

    task automatic reset_bank_model();
        shift_q        = SHIFT_MARKER;
        control_q      = CONTROL_RESET;
        prg_count_q    = PRG_COUNT_RESET;
        chr_count_q    = CHR_COUNT_RESET;
        lower_bank_q   = '0;
        upper_bank_q   = top_prg_bank();
        pattern_bank_q = '0;
    endtask

    function automatic t_result next_bank_report(
        input logic [ADDR_W-1:0] addr,
        input logic [DATA_W-1:0] data
    );
        t_result                rep;
        logic [SHIFT_W-1:0]     loaded;
        logic [1:0]             mode;
        logic [PRG_BANK_W-1:0]  bank;
        rep = '0;
        if (addr >= WINDOW_BASE) begin
            rep.handled = 1'b1;
            if (data[7]) begin
                shift_q = SHIFT_MARKER;
            end else begin
                loaded = {data[0], shift_q[SHIFT_W-1:1]};
                if (!shift_q[0]) begin
                    shift_q = loaded;
                end else begin
                    rep.register_loaded = 1'b1;
                    shift_q = SHIFT_MARKER;
                    mode = control_q[3:2];
                    case (t_target'(addr[14:13]))
                        TGT_CONTROL: begin
                            control_q = loaded;
                            if (loaded[3:2] == PRG_MODE_FIX_LOWER) begin
                                lower_bank_q = '0;
                            end else if (loaded[3:2] == PRG_MODE_FIX_UPPER) begin
                                upper_bank_q = top_prg_bank();
                            end
                        end
                        TGT_CHR0: begin
                            if (!control_q[CHR_MODE_BIT]) begin
                                pattern_bank_q = {1'b0, loaded[SHIFT_W-1:1]};
                                rep.bank_out_of_range =
                                    (int'(pattern_bank_q) >= chr_banks_present());
                            end
                        end
                        TGT_PRG: begin
                            bank = loaded[PRG_BANK_W-1:0];
                            rep.bank_out_of_range = (int'(bank) >= prg_banks_present());
                            if (mode == PRG_MODE_FIX_UPPER) begin
                                lower_bank_q = bank;
                            end else if (mode == PRG_MODE_FIX_LOWER) begin
                                upper_bank_q = bank;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
        rep.prg_lower_bank = lower_bank_q;
        rep.prg_upper_bank = upper_bank_q;
        rep.chr_bank       = pattern_bank_q;
        rep.mirror_mode    = control_q[1:0];
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on %s, report %0d: expected %0d, got %0d",
                         name, reports_checked, exp_v, act_v);
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : predict_writes
        t_result rep;
        if (i_rst_n && i_valid && !o_stall) begin
            rep = next_bank_report(i_addr, i_data);
            pending_reports.push_back(rep);
            writes_taken++;
            if (rep.register_loaded) loads_taken++;
        end
    end

    always @(posedge i_clk) begin : check_reports
        t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected report after %0d checked", reports_checked);
                end
            end else begin
                exp_r = pending_reports.pop_front();
                check_field("handled", 8'(exp_r.handled), 8'(o_handled));
                check_field("register_loaded", 8'(exp_r.register_loaded),
                            8'(o_register_loaded));
                check_field("prg_lower_bank", 8'(exp_r.prg_lower_bank),
                            8'(o_prg_lower_bank));
                check_field("prg_upper_bank", 8'(exp_r.prg_upper_bank),
                            8'(o_prg_upper_bank));
                check_field("chr_bank", 8'(exp_r.chr_bank), 8'(o_chr_bank));
                check_field("mirror_mode", 8'(exp_r.mirror_mode), 8'(o_mirror_mode));
                check_field("bank_out_of_range", 8'(exp_r.bank_out_of_range),
                            8'(o_bank_out_of_range));
            end
            reports_checked++;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_addr  <= addr;
        i_data  <= data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic load_register(input t_target tgt, input logic [SHIFT_W-1:0] value);
        for (int i = 0; i < SHIFT_W; i++) begin
            send_write({1'b1, tgt, 13'($urandom)}, {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_PRG_COUNT) begin
            prg_count_q = value[PRG_COUNT_W-1:0];
        end else if (idx == CFG_CHR_COUNT) begin
            chr_count_q = value;
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_outside_window();
        send_write(16'h0000, 8'h00);
        send_write(16'h7FFF, 8'hFF);
    endtask

    task automatic test_reset_byte();
        send_write(16'h8000, 8'h01);
        send_write(16'h8000, 8'h00);
        send_write(16'hFFFF, 8'h80);
    endtask

    task automatic test_control_load();
        load_register(TGT_CONTROL, 5'b01011);
    endtask

    task automatic test_bank_loads();
        load_register(TGT_CHR0, 5'b11111);
        load_register(TGT_PRG, 5'b11111);
        load_register(TGT_CHR1, 5'b10101);
    endtask

    task automatic test_random_traffic();
        int                    idx;
        int                    pick;
        int                    taken;
        int                    partial;
        logic [CFG_DATA_W-1:0] prg_val;
        logic [CFG_DATA_W-1:0] chr_val;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 19 : 0;
            for (int k = 0; k < 4; k++) begin
                idx = phase * 4 + k;
                case (idx)
                    0: begin prg_val = 6'd0;  chr_val = 6'd0;  end
                    1: begin prg_val = 6'd16; chr_val = 6'd32; end
                    2: begin prg_val = 6'd31; chr_val = 6'd63; end
                    3: begin prg_val = 6'd1;  chr_val = 6'd1;  end
                    4: begin prg_val = 6'd47; chr_val = 6'd33; end
                    5: begin prg_val = 6'd17; chr_val = 6'd31; end
                    default: begin
                        prg_val = 6'($urandom);
                        chr_val = 6'($urandom);
                    end
                endcase
                wait_idle();
                write_count(CFG_PRG_COUNT, prg_val);
                write_count(CFG_CHR_COUNT, chr_val);
                write_count(($urandom_range(1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                            6'($urandom));
                count_settings++;
                taken = 0;
                while (taken < BLOCK_WRITES) begin
                    pick = $urandom_range(99);
                    if (pick < 70) begin
                        load_register(t_target'($urandom_range(3)), 5'($urandom));
                        taken += SHIFT_W;
                    end else if (pick < 80) begin
                        send_write({1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
                        taken++;
                    end else if (pick < 90) begin
                        send_write({1'b0, 15'($urandom)}, 8'($urandom));
                        taken++;
                    end else begin
                        partial = $urandom_range(1, SHIFT_W - 1);
                        for (int i = 0; i < partial; i++) begin
                            send_write({1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
                        end
                        taken += partial;
                    end
                end
            end
        end
    endtask

    initial begin
        reset_bank_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_outside_window();
        test_reset_byte();
        test_control_load();
        test_bank_loads();
        test_random_traffic();

        wait_idle();
        $display("covered %0d bus writes, %0d completing a register load,",
                 writes_taken, loads_taken);
        $display("over %0d bank count settings and three idle profiles; %0d reports checked",
                 count_settings, reports_checked);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/slbm_pkg.sv
rtl/slbm_core.sv
rtl/serial_loaded_bank_mapper.sv
dv/tb_serial_loaded_bank_mapper.sv
